FILE: src/nsd_pkg.sv
// ----------------------------------------------------------------------------
// nsd_pkg: shared types and constants
// Beat payloads, queue entry and table entry for the nearest segment search.
// ----------------------------------------------------------------------------
package nsd_pkg;

   localparam int MAX_SEGMENTS = 16;
   localparam int SLOT_W       = $clog2(MAX_SEGMENTS);
   localparam int COUNT_W      = 5;
   localparam int COORD_W      = 24;
   localparam int DIST_W       = 25;

   localparam logic [DIST_W-1:0]  DIST_MAX  = {DIST_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_SEGMENTS);

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } op_kind_type;

   // request beat
   typedef struct packed {
      logic                      cmd;
      logic [SLOT_W-1:0]         slot;
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
   } req_type;

   // response beat
   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [SLOT_W-1:0] nearest_slot;
      logic              no_segments;
   } rsp_type;

   // one table entry
   typedef struct packed {
      logic signed [COORD_W-1:0] sx;
      logic signed [COORD_W-1:0] sy;
      logic signed [COORD_W-1:0] ex;
      logic signed [COORD_W-1:0] ey;
   } seg_type;

   // classified work item; a query carries its point in seg.sx / seg.sy
   typedef struct packed {
      op_kind_type       kind;
      logic [SLOT_W-1:0] slot;
      seg_type           seg;
   } op_type;

   // queue head toward the engine
   typedef struct packed {
      logic   valid;
      op_type op;
   } queue_head_type;

endpackage

FILE: src/nsd_front.sv
// ----------------------------------------------------------------------------
// nsd_front: request intake and work queue
// Accepts request beats, classifies them into load or query items and holds
// them in a two-entry queue in front of the engine.
// ----------------------------------------------------------------------------
module nsd_front import nsd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  req_type        req_data,
   output queue_head_type head,
   input  logic           head_pop
);

   op_type      ent_ff [2];
   op_type      ent_in;
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  fill_ff, fill_in;
   logic        push, pop;

   // classify the beat
   always_comb begin
      ent_in.slot = req_data.slot;
      if (req_data.cmd == OP_QUERY) begin
         ent_in.kind   = OP_QUERY;
         ent_in.seg.sx = req_data.point_x;
         ent_in.seg.sy = req_data.point_y;
         ent_in.seg.ex = req_data.end_x;
         ent_in.seg.ey = req_data.end_y;
      end else begin
         ent_in.kind   = OP_LOAD;
         ent_in.seg.sx = req_data.start_x;
         ent_in.seg.sy = req_data.start_y;
         ent_in.seg.ex = req_data.end_x;
         ent_in.seg.ey = req_data.end_y;
      end
   end

   assign req_ready  = (fill_ff != 2'd2);
   assign push       = req_valid && req_ready;
   assign pop        = head_pop && (fill_ff != 2'd0);
   assign head.valid = (fill_ff != 2'd0);
   assign head.op    = ent_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= ent_in;
      end
   end

endmodule

FILE: src/nsd_engine.sv
// ----------------------------------------------------------------------------
// nsd_engine: segment table and distance search
// Holds the segment table, walks the slots in use for a query with one shared
// multiplier, a bit-serial divider and a bit-serial square root, and keeps the
// response in an output register.
// ----------------------------------------------------------------------------
module nsd_engine import nsd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [COUNT_W-1:0]  seg_count,
   input  queue_head_type      head,
   output logic                head_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_data
);

   localparam int DW      = COORD_W + 1;     // coordinate differences
   localparam int MW      = DW + 1;          // multiplier operands
   localparam int PW      = 2 * MW;          // product
   localparam int LW      = 2 * COORD_W + 2; // squared length, quotient
   localparam int MAGW    = 2 * COORD_W + 1; // cross product magnitude
   localparam int LOW     = DW;              // low part of the magnitude
   localparam int NUMW    = 2 * MAGW;        // squared cross product
   localparam int AW      = NUMW + 1;        // accumulator
   localparam int CW      = 6;
   localparam int DIV_N   = MAGW;            // quotient bits
   localparam int SQRT_N  = LW / 2;          // root bits

   typedef enum logic [19:0] {
      ST_IDLE = 20'h00001,
      ST_RD   = 20'h00002,
      ST_DIFF = 20'h00004,
      ST_L0   = 20'h00008,
      ST_L1   = 20'h00010,
      ST_D0   = 20'h00020,
      ST_D1   = 20'h00040,
      ST_SEL  = 20'h00080,
      ST_E0   = 20'h00100,
      ST_E1   = 20'h00200,
      ST_C0   = 20'h00400,
      ST_C1   = 20'h00800,
      ST_CABS = 20'h01000,
      ST_H0   = 20'h02000,
      ST_H1   = 20'h04000,
      ST_H2   = 20'h08000,
      ST_DIV  = 20'h10000,
      ST_SQRT = 20'h20000,
      ST_CMP  = 20'h40000,
      ST_OUT  = 20'h80000
   } state_type;

   state_type                 state_ff, state_in;
   seg_type                   seg_mem_ff [MAX_SEGMENTS];
   seg_type                   rd_ff;
   logic [COUNT_W-1:0]        idx_ff, idx_in;
   logic [COUNT_W-1:0]        n_ff, n_in;
   logic signed [COORD_W-1:0] pt_x_ff, pt_x_in, pt_y_ff, pt_y_in;
   logic signed [DW-1:0]      dx_ff, dy_ff, px_ff, py_ff, qx_ff, qy_ff;
   logic signed [DW-1:0]      dx_in, dy_in, px_in, py_in, qx_in, qy_in;
   logic signed [AW-1:0]      acc_ff, acc_in;
   logic [LW-1:0]             len2_ff, len2_in;
   logic                      far_ff, far_in;
   logic [MAGW-1:0]           mag_ff, mag_in;
   logic [LW-1:0]             rem_ff, rem_in;
   logic [DIV_N-1:0]          shr_ff, shr_in;
   logic [LW-1:0]             op_ff, op_in, res_ff, res_in, one_ff, one_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic [DIST_W-1:0]         best_ff, best_in;
   logic [SLOT_W-1:0]         bslot_ff, bslot_in;
   logic                      found_ff, found_in, none_ff, none_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   logic signed [MW-1:0]      mul_a, mul_b;
   logic signed [PW-1:0]      prod;
   logic signed [AW-1:0]      prod_ext, acc_sum;
   logic                      mem_we;
   logic [LW:0]               div_trial, div_diff;
   logic                      div_ge;
   logic [DIV_N-1:0]          div_q;
   logic [LW-1:0]             sq_trial, sq_res;
   logic                      sq_ge;
   logic                      out_free;
   logic [COUNT_W-1:0]        idx_next;

   assign head_pop  = (state_ff == ST_IDLE);
   assign mem_we    = (state_ff == ST_IDLE) && head.valid && (head.op.kind == OP_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign idx_next  = idx_ff + COUNT_W'(1);

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_L0: begin mul_a = MW'(dx_ff); mul_b = MW'(dx_ff); end
         ST_L1: begin mul_a = MW'(dy_ff); mul_b = MW'(dy_ff); end
         ST_D0: begin mul_a = MW'(px_ff); mul_b = MW'(dx_ff); end
         ST_D1: begin mul_a = MW'(py_ff); mul_b = MW'(dy_ff); end
         ST_E0: begin
            mul_a = far_ff ? MW'(qx_ff) : MW'(px_ff);
            mul_b = mul_a;
         end
         ST_E1: begin
            mul_a = far_ff ? MW'(qy_ff) : MW'(py_ff);
            mul_b = mul_a;
         end
         ST_C0: begin mul_a = MW'(px_ff); mul_b = MW'(dy_ff); end
         ST_C1: begin mul_a = MW'(py_ff); mul_b = MW'(dx_ff); end
         ST_H0: begin
            mul_a = $signed(MW'(mag_ff[MAGW-1:LOW]));
            mul_b = mul_a;
         end
         ST_H1: begin
            mul_a = $signed(MW'(mag_ff[MAGW-1:LOW]));
            mul_b = $signed(MW'(mag_ff[LOW-1:0]));
         end
         ST_H2: begin
            mul_a = $signed(MW'(mag_ff[LOW-1:0]));
            mul_b = mul_a;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod     = mul_a * mul_b;
   assign prod_ext = AW'(prod);
   assign acc_sum  = acc_ff + prod_ext;

   // divider step: one quotient bit
   assign div_trial = {rem_ff, shr_ff[DIV_N-1]};
   assign div_ge    = (div_trial >= {1'b0, len2_ff});
   assign div_diff  = div_trial - {1'b0, len2_ff};
   assign div_q     = {shr_ff[DIV_N-2:0], div_ge};

   // square root step: one root bit
   assign sq_trial = res_ff + one_ff;
   assign sq_ge    = (op_ff >= sq_trial);
   assign sq_res   = sq_ge ? ((res_ff >> 1) + one_ff) : (res_ff >> 1);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      pt_x_in      = pt_x_ff;
      pt_y_in      = pt_y_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      acc_in       = acc_ff;
      len2_in      = len2_ff;
      far_in       = far_ff;
      mag_in       = mag_ff;
      rem_in       = rem_ff;
      shr_in       = shr_ff;
      op_in        = op_ff;
      res_in       = res_ff;
      one_in       = one_ff;
      cnt_in       = cnt_ff;
      best_in      = best_ff;
      bslot_in     = bslot_ff;
      found_in     = found_ff;
      none_in      = none_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid && (head.op.kind == OP_QUERY)) begin
               pt_x_in  = head.op.seg.sx;
               pt_y_in  = head.op.seg.sy;
               n_in     = (seg_count > COUNT_MAX) ? COUNT_MAX : seg_count;
               idx_in   = '0;
               found_in = 1'b0;
               if (seg_count == '0) begin
                  best_in  = DIST_MAX;
                  bslot_in = '0;
                  none_in  = 1'b1;
                  state_in = ST_OUT;
               end else begin
                  none_in  = 1'b0;
                  state_in = ST_RD;
               end
            end
         end
         ST_RD: begin
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            dx_in    = DW'(rd_ff.ex) - DW'(rd_ff.sx);
            dy_in    = DW'(rd_ff.ey) - DW'(rd_ff.sy);
            px_in    = DW'(pt_x_ff) - DW'(rd_ff.sx);
            py_in    = DW'(pt_y_ff) - DW'(rd_ff.sy);
            qx_in    = DW'(pt_x_ff) - DW'(rd_ff.ex);
            qy_in    = DW'(pt_y_ff) - DW'(rd_ff.ey);
            state_in = ST_L0;
         end
         ST_L0: begin
            acc_in   = prod_ext;
            state_in = ST_L1;
         end
         ST_L1: begin
            len2_in  = acc_sum[LW-1:0];
            state_in = ST_D0;
         end
         ST_D0: begin
            acc_in   = prod_ext;
            state_in = ST_D1;
         end
         ST_D1: begin
            acc_in   = acc_sum;
            state_in = ST_SEL;
         end
         // pick start point, end point or perpendicular foot
         ST_SEL: begin
            if ((len2_ff == '0) || (acc_ff <= 0)) begin
               far_in   = 1'b0;
               state_in = ST_E0;
            end else if ($signed({{(AW-LW){1'b0}}, len2_ff}) <= acc_ff) begin
               far_in   = 1'b1;
               state_in = ST_E0;
            end else begin
               state_in = ST_C0;
            end
         end
         ST_E0: begin
            acc_in   = prod_ext;
            state_in = ST_E1;
         end
         ST_E1: begin
            op_in    = acc_sum[LW-1:0];
            res_in   = '0;
            one_in   = LW'(1) << (LW - 2);
            cnt_in   = '0;
            state_in = ST_SQRT;
         end
         ST_C0: begin
            acc_in   = prod_ext;
            state_in = ST_C1;
         end
         ST_C1: begin
            acc_in   = acc_ff - prod_ext;
            state_in = ST_CABS;
         end
         ST_CABS: begin
            mag_in   = acc_ff[AW-1] ? MAGW'(-acc_ff) : acc_ff[MAGW-1:0];
            state_in = ST_H0;
         end
         ST_H0: begin
            acc_in   = prod_ext <<< (2 * LOW);
            state_in = ST_H1;
         end
         ST_H1: begin
            acc_in   = acc_ff + (prod_ext <<< (LOW + 1));
            state_in = ST_H2;
         end
         ST_H2: begin
            rem_in   = LW'(acc_sum[NUMW-1:DIV_N]);
            shr_in   = acc_sum[DIV_N-1:0];
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = div_ge ? div_diff[LW-1:0] : div_trial[LW-1:0];
            shr_in = div_q;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(DIV_N - 1)) begin
               op_in    = LW'(div_q);
               res_in   = '0;
               one_in   = LW'(1) << (LW - 2);
               cnt_in   = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sq_ge) begin
               op_in = op_ff - sq_trial;
            end
            res_in = sq_res;
            one_in = one_ff >> 2;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(SQRT_N - 1)) begin
               state_in = ST_CMP;
            end
         end
         // keep the first smallest distance
         ST_CMP: begin
            if (!found_ff || (res_ff[DIST_W-1:0] < best_ff)) begin
               best_in  = res_ff[DIST_W-1:0];
               bslot_in = idx_ff[SLOT_W-1:0];
               found_in = 1'b1;
            end
            idx_in   = idx_next;
            state_in = (idx_next == n_ff) ? ST_OUT : ST_RD;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_in.distance     = best_ff;
               rsp_in.nearest_slot = bslot_ff;
               rsp_in.no_segments  = none_ff;
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      n_ff     <= n_in;
      pt_x_ff  <= pt_x_in;
      pt_y_ff  <= pt_y_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      qx_ff    <= qx_in;
      qy_ff    <= qy_in;
      acc_ff   <= acc_in;
      len2_ff  <= len2_in;
      far_ff   <= far_in;
      mag_ff   <= mag_in;
      rem_ff   <= rem_in;
      shr_ff   <= shr_in;
      op_ff    <= op_in;
      res_ff   <= res_in;
      one_ff   <= one_in;
      cnt_ff   <= cnt_in;
      best_ff  <= best_in;
      bslot_ff <= bslot_in;
      found_ff <= found_in;
      none_ff  <= none_in;
      rsp_ff   <= rsp_in;
   end

   // segment table: write on load, registered read per slot
   always_ff @(posedge clock) begin
      if (mem_we) begin
         seg_mem_ff[head.op.slot] <= head.op.seg;
      end
      if (state_ff == ST_RD) begin
         rd_ff <= seg_mem_ff[idx_ff[SLOT_W-1:0]];
      end
   end

endmodule

FILE: src/nearest_segment_distance.sv
// ----------------------------------------------------------------------------
// nearest_segment_distance: nearest line segment to a query point
// Segment table with load and query beats, one response beat per query.
// ----------------------------------------------------------------------------
// Load: written to the table as it leaves the queue. Query: each slot in use
// is measured to its nearest endpoint or, inside the segment, to the line
// (shared multiplier, 49-step divider, 25-step square root).
// A two-entry queue takes new beats while the engine works.
// Reset: segment count 0, queue and response empty; table contents undefined.
module nearest_segment_distance import nsd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [COUNT_W-1:0] csr_data
);

   logic [COUNT_W-1:0] count_ff, count_in;
   queue_head_type     head;
   logic               head_pop;

   // segment count register
   assign csr_ready = 1'b1;
   assign count_in  = (csr_valid && csr_ready) ? csr_data : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   nsd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .head      (head),
      .head_pop  (head_pop)
   );

   nsd_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .seg_count (count_ff),
      .head      (head),
      .head_pop  (head_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // empty table answers with the saturated distance and slot 0
   a_none_max : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.no_segments |->
         (rsp_data.distance == DIST_MAX) && (rsp_data.nearest_slot == '0))
      else $error("empty-table response carries wrong fields");

   // a found slot lies inside the searched range
   a_slot_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.no_segments |->
         ({1'b0, rsp_data.nearest_slot} < count_ff) && (count_ff != '0))
      else $error("nearest slot outside the slots in use");

endmodule
